@@ rtl/i2cm_pkg.sv @@
`default_nettype none

package i2cm_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int CMD_W       = 3;
  localparam int PHASE_W     = 4;
  localparam int BIT_IDX_W   = 4;
  localparam int DELAY_W     = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;

  // command codes, also used as the running operation
  localparam logic [CMD_W-1:0] OP_IDLE  = 3'd0;  // tick when given as a command
  localparam logic [CMD_W-1:0] OP_START = 3'd1;
  localparam logic [CMD_W-1:0] OP_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] OP_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] OP_READ  = 3'd4;
  localparam logic [CMD_W-1:0] OP_SACK  = 3'd5;
  localparam logic [CMD_W-1:0] OP_RACK  = 3'd6;

  localparam logic [PHASE_W-1:0] PH_0 = 4'd0;
  localparam logic [PHASE_W-1:0] PH_1 = 4'd1;
  localparam logic [PHASE_W-1:0] PH_2 = 4'd2;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 ack_bit;
    logic                 sda_level;
  } item_t;

  typedef struct packed {
    logic                 rejected;
    logic                 ack_received;
    logic [BYTE_BITS-1:0] read_byte;
    logic                 done_res;
    logic                 busy_res;
    logic                 sda_is_input;
    logic                 sda_out;
    logic                 scl_out;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/i2cm_core.sv @@
`default_nettype none

module i2cm_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire i2cm_pkg::item_t                item_i,
  input  wire logic [i2cm_pkg::DELAY_W-1:0]   delay_ticks_i,
  output i2cm_pkg::result_t                   res_o
);

  logic [i2cm_pkg::CMD_W-1:0]     op_q, op_d;
  logic [i2cm_pkg::PHASE_W-1:0]   phase_q, phase_d;
  logic [i2cm_pkg::BIT_IDX_W-1:0] bit_idx_q, bit_idx_d;
  logic [i2cm_pkg::DELAY_W-1:0]   cnt_q, cnt_d;
  logic [i2cm_pkg::BYTE_BITS-1:0] shift_q, shift_d;
  logic [i2cm_pkg::BYTE_BITS-1:0] rd_q, rd_d;
  logic scl_q, scl_d, sda_q, sda_d, sdain_q, sdain_d, ack_q, ack_d;

  logic                           busy;
  logic                           done;
  logic                           rej;
  logic [i2cm_pkg::DELAY_W-1:0]   limit;
  logic [i2cm_pkg::DELAY_W-1:0]   cnt_inc;
  logic [i2cm_pkg::BIT_IDX_W-1:0] bit_inc;
  logic [i2cm_pkg::PHASE_W-1:0]   phase_inc;
  logic [i2cm_pkg::BYTE_BITS-1:0] shift_wr;
  logic [i2cm_pkg::BYTE_BITS-1:0] shift_rd;
  logic                           last_bit;

  assign busy      = (op_q != i2cm_pkg::OP_IDLE);
  assign limit     = (delay_ticks_i == '0) ? i2cm_pkg::DELAY_W'(1) : delay_ticks_i;
  assign cnt_inc   = cnt_q + i2cm_pkg::DELAY_W'(1);
  assign bit_inc   = bit_idx_q + i2cm_pkg::BIT_IDX_W'(1);
  assign phase_inc = phase_q + i2cm_pkg::PHASE_W'(1);
  assign shift_wr  = {shift_q[i2cm_pkg::BYTE_BITS-2:0], 1'b0};
  assign shift_rd  = {shift_q[i2cm_pkg::BYTE_BITS-2:0], item_i.sda_level};
  assign last_bit  = (bit_inc >= i2cm_pkg::BIT_IDX_W'(i2cm_pkg::BYTE_BITS));

  always_comb begin
    op_d      = op_q;
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    rd_d      = rd_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    sdain_d   = sdain_q;
    ack_d     = ack_q;
    done      = 1'b0;
    rej       = 1'b0;

    if (item_i.command == i2cm_pkg::OP_IDLE) begin
      // timing tick
      if (busy) begin
        cnt_d = cnt_inc;
        if (cnt_inc >= limit) begin
          cnt_d   = '0;
          phase_d = phase_inc;
          unique case (op_q)
            i2cm_pkg::OP_START: begin
              if (phase_q == i2cm_pkg::PH_0) scl_d = 1'b0;
              else done = 1'b1;
            end
            i2cm_pkg::OP_STOP: begin
              if (phase_q == i2cm_pkg::PH_0) scl_d = 1'b1;
              else if (phase_q == i2cm_pkg::PH_1) sda_d = 1'b1;
              else done = 1'b1;
            end
            i2cm_pkg::OP_WRITE: begin
              if (phase_q == i2cm_pkg::PH_0) begin
                scl_d = 1'b1;
              end else begin
                scl_d     = 1'b0;
                bit_idx_d = bit_inc;
                if (last_bit) begin
                  sda_d = 1'b1;
                  done  = 1'b1;
                end else begin
                  shift_d = shift_wr;
                  sda_d   = shift_wr[i2cm_pkg::BYTE_BITS-1];
                  phase_d = i2cm_pkg::PH_0;
                end
              end
            end
            i2cm_pkg::OP_READ: begin
              if (phase_q == i2cm_pkg::PH_0) begin
                scl_d = 1'b1;
              end else begin
                shift_d   = shift_rd;
                scl_d     = 1'b0;
                bit_idx_d = bit_inc;
                if (last_bit) begin
                  sdain_d = 1'b0;
                  rd_d    = shift_rd;
                  done    = 1'b1;
                end else begin
                  phase_d = i2cm_pkg::PH_0;
                end
              end
            end
            i2cm_pkg::OP_SACK: begin
              if (phase_q == i2cm_pkg::PH_0) scl_d = 1'b1;
              else if (phase_q == i2cm_pkg::PH_1) scl_d = 1'b0;
              else begin
                sda_d = 1'b1;
                done  = 1'b1;
              end
            end
            i2cm_pkg::OP_RACK: begin
              if (phase_q == i2cm_pkg::PH_0) scl_d = 1'b1;
              else if (phase_q == i2cm_pkg::PH_1) begin
                ack_d = ~item_i.sda_level;
                scl_d = 1'b0;
              end else if (phase_q == i2cm_pkg::PH_2) sdain_d = 1'b0;
              else done = 1'b1;
            end
            default: done = 1'b1;
          endcase
          if (done) begin
            op_d    = i2cm_pkg::OP_IDLE;
            phase_d = i2cm_pkg::PH_0;
          end
        end
      end
    end else if (item_i.command <= i2cm_pkg::OP_RACK) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        op_d      = item_i.command;
        phase_d   = i2cm_pkg::PH_0;
        bit_idx_d = '0;
        cnt_d     = '0;
        unique case (item_i.command)
          i2cm_pkg::OP_START, i2cm_pkg::OP_STOP: sda_d = 1'b0;
          i2cm_pkg::OP_WRITE: begin
            shift_d = item_i.data_byte;
            sda_d   = item_i.data_byte[i2cm_pkg::BYTE_BITS-1];
          end
          i2cm_pkg::OP_READ: begin
            shift_d = '0;
            sdain_d = 1'b1;
          end
          i2cm_pkg::OP_SACK: sda_d = ~item_i.ack_bit;
          default: sdain_d = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= i2cm_pkg::OP_IDLE;
      phase_q   <= '0;
      bit_idx_q <= '0;
      cnt_q     <= '0;
      shift_q   <= '0;
      rd_q      <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      sdain_q   <= 1'b0;
      ack_q     <= 1'b0;
    end else if (step_i) begin
      op_q      <= op_d;
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      cnt_q     <= cnt_d;
      shift_q   <= shift_d;
      rd_q      <= rd_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      sdain_q   <= sdain_d;
      ack_q     <= ack_d;
    end
  end

  always_comb begin
    res_o.scl_out      = scl_d;
    res_o.sda_out      = sda_d;
    res_o.sda_is_input = sdain_d;
    res_o.busy_res     = (op_d != i2cm_pkg::OP_IDLE);
    res_o.done_res     = done;
    res_o.read_byte    = rd_d;
    res_o.ack_received = ack_d;
    res_o.rejected     = rej;
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |-> !res_o.busy_res && busy)
    else $error("done without going idle");

  a_rej_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && rej |=> $stable(op_q) && $stable(phase_q) && $stable(cnt_q))
    else $error("rejected command changed state");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_idx_q <= i2cm_pkg::BIT_IDX_W'(i2cm_pkg::BYTE_BITS))
    else $error("bit index past byte end");

  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && rej |-> busy && !done)
    else $error("reject while idle");

endmodule

`default_nettype wire

@@ rtl/i2c_master_bit_engine_top.sv @@
// channel  direction  handshake                   payload
// s_axis   in         s_axis_tvalid/tready        tuser command, tdata byte/ack/sda
// m_axis   out        m_axis_tvalid/tready        tdata pin levels and status
// cfg      in         cfg_valid/cfg_ready         delay_ticks, 16 bits
//
// every accepted word gives exactly one result word, through the input register and then the result register
// one word per cycle sustained while the output is not stalled: input register, then one pass of sequencer logic
// into the result register; the line state updates when a word leaves the input register
// a stalled output holds its word; the input register still takes a word while it is empty,
// or while the result register is free or draining in the same cycle
// reset: scl and sda released, sequencer idle, delay_ticks 100
`default_nettype none

module i2c_master_bit_engine_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] data_byte, [8] ack_bit, [9] sda_level, [15:10] zero
  input  wire logic [i2cm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [2:0] command
  input  wire logic [i2cm_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] scl_out, [1] sda_out, [2] sda_is_input, [3] busy_res, [4] done_res,
  // [12:5] read_byte, [13] ack_received, [14] rejected, [15] zero
  output logic [i2cm_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [i2cm_pkg::DELAY_W-1:0]      cfg_data
);

  i2cm_pkg::item_t                item_q;
  logic                           in_vld_q;
  i2cm_pkg::result_t              res;
  i2cm_pkg::result_t              out_q;
  logic                           out_vld_q;
  logic [i2cm_pkg::DELAY_W-1:0]   delay_q;
  logic                           advance;
  logic                           in_acc;

  // a word moves on when the result register is empty or being drained
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= i2cm_pkg::DELAY_RESET;
    end else if (cfg_valid) begin
      delay_q <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.command   <= s_axis_tuser;
      item_q.data_byte <= s_axis_tdata[7:0];
      item_q.ack_bit   <= s_axis_tdata[8];
      item_q.sda_level <= s_axis_tdata[9];
    end
  end

  i2cm_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (item_q),
    .delay_ticks_i (delay_q),
    .res_o         (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q};

endmodule

`default_nettype wire
